// File: rtl/core/jan_pkg.sv
// ----------------------------------------------------------------------------
// jan_pkg
// Shared widths, constants and types of the joystick axis normalizer.
// ----------------------------------------------------------------------------
package jan_pkg;

  // Field widths
  localparam int SAMPLE_BITS  = 10;
  localparam int BUTTON_COUNT = 7;
  localparam int NORM_BITS    = SAMPLE_BITS + 1;
  localparam int POLL_BITS    = 32;

  // Normalized scale: the centre maps to 512, the peak to 1024
  localparam int NORM_SHIFT = 9;
  localparam logic [NORM_BITS-1:0] NORM_MID = NORM_BITS'(512);

  // Divider operand widths
  localparam int NUM_BITS = SAMPLE_BITS + NORM_SHIFT;
  localparam int CNT_BITS = $clog2(NUM_BITS);

  // Configuration port
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;
  localparam int REG_BITS  = 3;

  typedef enum logic [REG_BITS-1:0] {
    REG_CENTRE_X      = 3'd0,
    REG_CENTRE_Y      = 3'd1,
    REG_ACTIVE_LEVELS = 3'd2,
    REG_DISABLED_MASK = 3'd3,
    REG_CLICK_MASK    = 3'd4
  } reg_index_t;

  // Reset values of the configuration registers
  localparam logic [SAMPLE_BITS-1:0]  CENTRE_RESET = SAMPLE_BITS'(512);
  localparam logic [BUTTON_COUNT-1:0] ACTIVE_RESET = 7'b0111111;
  localparam logic [BUTTON_COUNT-1:0] CLICK_RESET  = 7'b1110000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_X_GO,
    ST_X_WAIT,
    ST_Y_GO,
    ST_Y_WAIT,
    ST_HOLD
  } state_t;

endpackage

// File: rtl/core/jan_poll_if.sv
// ----------------------------------------------------------------------------
// jan_poll_if
// Input channel: one joystick poll per transaction.
// ----------------------------------------------------------------------------
interface jan_poll_if;
  import jan_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SAMPLE_BITS-1:0]  sample_x;
  logic [SAMPLE_BITS-1:0]  sample_y;
  logic [BUTTON_COUNT-1:0] pin_levels;

  modport source (output valid, sample_x, sample_y, pin_levels, input ready);
  modport sink   (input valid, sample_x, sample_y, pin_levels, output ready);

endinterface

// File: rtl/core/jan_report_if.sv
// ----------------------------------------------------------------------------
// jan_report_if
// Output channel: one normalized report per transaction.
// ----------------------------------------------------------------------------
interface jan_report_if;
  import jan_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SAMPLE_BITS-1:0]  raw_x;
  logic [SAMPLE_BITS-1:0]  raw_y;
  logic [NORM_BITS-1:0]    norm_x;
  logic [NORM_BITS-1:0]    norm_y;
  logic [BUTTON_COUNT-1:0] pressed_bits;
  logic [BUTTON_COUNT-1:0] clicked_bits;
  logic [POLL_BITS-1:0]    poll_number;

  modport source (output valid, raw_x, raw_y, norm_x, norm_y, pressed_bits,
                  clicked_bits, poll_number, input ready);
  modport sink   (input valid, raw_x, raw_y, norm_x, norm_y, pressed_bits,
                  clicked_bits, poll_number, output ready);

endinterface

// File: rtl/core/jan_divider.sv
// ----------------------------------------------------------------------------
// jan_divider
// Restoring divider, one quotient bit per cycle, shared by both axes.
// ----------------------------------------------------------------------------
module jan_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [jan_pkg::NUM_BITS-1:0]  numer,
  input  logic [jan_pkg::SAMPLE_BITS-1:0] denom,
  output logic                          done,
  output logic [jan_pkg::SAMPLE_BITS-1:0] quotient
);
  import jan_pkg::*;

  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(NUM_BITS - 1);

  logic                   busy;
  logic [CNT_BITS-1:0]    count;
  logic [SAMPLE_BITS-1:0] den;
  logic [SAMPLE_BITS-1:0] rem;
  logic [NUM_BITS-1:0]    quo;

  logic [SAMPLE_BITS:0]   rem_shift;
  logic [SAMPLE_BITS+1:0] diff;
  logic                   fits;
  logic [SAMPLE_BITS-1:0] rem_next;

  // One trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    rem_shift = {rem, quo[NUM_BITS-1]};
    diff      = {1'b0, rem_shift} - {2'b00, den};
    fits      = ~diff[SAMPLE_BITS+1];
    rem_next  = fits ? diff[SAMPLE_BITS-1:0] : rem_shift[SAMPLE_BITS-1:0];
  end

  // Control: the step counter and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the numerator shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      den <= denom;
      rem <= '0;
      quo <= numer;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NUM_BITS-2:0], fits};
    end
  end

  assign quotient = quo[SAMPLE_BITS-1:0];

endmodule

// File: rtl/core/joystick_axis_normalizer_with_clicks.sv
// ----------------------------------------------------------------------------
// joystick_axis_normalizer_with_clicks
// Normalizes two joystick axes around a calibrated centre and decodes buttons.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the poll channel carries two axis samples and seven
//   button pin levels. Each one yields exactly one transaction on the report
//   channel with the raw samples, the normalized axes (512 at the centre, 1024
//   at the running peak), the pressed and clicked button bits and the poll
//   count after increment.
//   Both axes go through one shared restoring divider that makes one quotient
//   bit per cycle over a 19-bit numerator. A poll goes from acceptance to a
//   loaded report through an accept step, per axis a start step, 19 divide
//   steps and a capture of the result, then a load step. The poll channel is
//   ready only while the sequencer is idle and out of reset, so a new poll is
//   taken only after the last one is loaded into the output register. The
//   report sits in that register; while the receiver stalls the next poll
//   may be accepted and processed, and it waits in the hold state until the
//   register frees up. Reset clears the peaks, the click trail and the poll
//   counter, and loads the configuration registers with their defaults
//   (centres 512, active levels 0111111, no disabled buttons, click mask
//   1110000). Configuration must be written over the APB port only while no
//   poll is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module joystick_axis_normalizer_with_clicks (
  input  logic                          clk,
  input  logic                          rst,
  jan_poll_if.sink                      poll,
  jan_report_if.source                  report,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jan_pkg::ADDR_BITS-1:0] paddr,
  input  logic [jan_pkg::DATA_BITS-1:0] pwdata,
  output logic [jan_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import jan_pkg::*;

  // Configuration registers
  logic [SAMPLE_BITS-1:0]  centre_x;
  logic [SAMPLE_BITS-1:0]  centre_y;
  logic [BUTTON_COUNT-1:0] active_levels;
  logic [BUTTON_COUNT-1:0] disabled_mask;
  logic [BUTTON_COUNT-1:0] click_mask;

  // Running state
  logic [SAMPLE_BITS-1:0]  peak_x;
  logic [SAMPLE_BITS-1:0]  peak_y;
  logic [BUTTON_COUNT-1:0] press_trail;
  logic [POLL_BITS-1:0]    poll_count;

  // Work registers of the poll in flight
  logic [SAMPLE_BITS-1:0]  sx;
  logic [SAMPLE_BITS-1:0]  sy;
  logic [BUTTON_COUNT-1:0] pressed;
  logic [BUTTON_COUNT-1:0] clicked;
  logic [NORM_BITS-1:0]    norm_x;
  logic [NORM_BITS-1:0]    norm_y;

  state_t state, state_next;
  logic   accept;
  logic   div_start;
  logic   load_out;
  logic   out_valid;

  logic                    cfg_write;
  reg_index_t              cfg_index;
  logic [BUTTON_COUNT-1:0] pressed_c;
  logic [BUTTON_COUNT-1:0] clicked_c;

  logic                    sel_y;
  logic [SAMPLE_BITS-1:0]  s;
  logic [SAMPLE_BITS-1:0]  c;
  logic [SAMPLE_BITS-1:0]  p;
  logic                    lower;
  logic [SAMPLE_BITS-1:0]  offset;
  logic [SAMPLE_BITS-1:0]  span;
  logic [NUM_BITS-1:0]     numer;
  logic [SAMPLE_BITS-1:0]  denom;
  logic                    div_done;
  logic [SAMPLE_BITS-1:0]  quotient;
  logic [NORM_BITS-1:0]    norm_c;

  // APB port: writes complete in the access phase, reads are combinational.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = reg_index_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x      <= CENTRE_RESET;
      centre_y      <= CENTRE_RESET;
      active_levels <= ACTIVE_RESET;
      disabled_mask <= '0;
      click_mask    <= CLICK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTRE_X:      centre_x      <= pwdata[SAMPLE_BITS-1:0];
        REG_CENTRE_Y:      centre_y      <= pwdata[SAMPLE_BITS-1:0];
        REG_ACTIVE_LEVELS: active_levels <= pwdata[BUTTON_COUNT-1:0];
        REG_DISABLED_MASK: disabled_mask <= pwdata[BUTTON_COUNT-1:0];
        REG_CLICK_MASK:    click_mask    <= pwdata[BUTTON_COUNT-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_CENTRE_X:      prdata = DATA_BITS'(centre_x);
      REG_CENTRE_Y:      prdata = DATA_BITS'(centre_y);
      REG_ACTIVE_LEVELS: prdata = DATA_BITS'(active_levels);
      REG_DISABLED_MASK: prdata = DATA_BITS'(disabled_mask);
      REG_CLICK_MASK:    prdata = DATA_BITS'(click_mask);
      default:           prdata = '0;
    endcase
  end

  // Button decode; click-style buttons fire on release after a press.
  always_comb begin
    pressed_c = ~(poll.pin_levels ^ active_levels) & ~disabled_mask;
    clicked_c = (pressed_c & ~click_mask) | (press_trail & ~pressed_c & click_mask);
  end

  assign accept = poll.valid & poll.ready;

  // Per-poll state updates at acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_x      <= '0;
      peak_y      <= '0;
      press_trail <= '0;
      poll_count  <= '0;
    end else if (accept) begin
      if (poll.sample_x > peak_x) begin
        peak_x <= poll.sample_x;
      end
      if (poll.sample_y > peak_y) begin
        peak_y <= poll.sample_y;
      end
      press_trail <= (press_trail & ~click_mask) | (pressed_c & click_mask);
      poll_count  <= poll_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sx      <= poll.sample_x;
      sy      <= poll.sample_y;
      pressed <= pressed_c;
      clicked <= clicked_c;
    end
  end

  // Axis operand selection for the shared divider.
  always_comb begin
    sel_y  = (state == ST_Y_GO) || (state == ST_Y_WAIT);
    s      = sel_y ? sy : sx;
    c      = sel_y ? centre_y : centre_x;
    p      = sel_y ? peak_y : peak_x;
    lower  = s < c;
    offset = s - c;
    span   = p - c;
    numer  = lower ? {s, NORM_SHIFT'(0)} : {offset, NORM_SHIFT'(0)};
    denom  = lower ? c : span;
    if (lower) begin
      norm_c = {1'b0, quotient};
    end else if (span == '0) begin
      norm_c = NORM_MID;
    end else begin
      norm_c = {1'b0, quotient} + NORM_MID;
    end
  end

  jan_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .denom    (denom),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (state == ST_X_WAIT && div_done) begin
      norm_x <= norm_c;
    end
    if (state == ST_Y_WAIT && div_done) begin
      norm_y <= norm_c;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_out   = 1'b0;
    poll.ready = 1'b0;
    case (state)
      ST_IDLE: begin
        poll.ready = ~rst;
        if (accept) begin
          state_next = ST_X_GO;
        end
      end
      ST_X_GO: begin
        div_start  = 1'b1;
        state_next = ST_X_WAIT;
      end
      ST_X_WAIT: begin
        if (div_done) begin
          state_next = ST_Y_GO;
        end
      end
      ST_Y_GO: begin
        div_start  = 1'b1;
        state_next = ST_Y_WAIT;
      end
      ST_Y_WAIT: begin
        if (div_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid || report.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      report.raw_x        <= sx;
      report.raw_y        <= sy;
      report.norm_x       <= norm_x;
      report.norm_y       <= norm_y;
      report.pressed_bits <= pressed;
      report.clicked_bits <= clicked;
      report.poll_number  <= poll_count;
    end
  end

  assign report.valid = out_valid;

endmodule
